// File: rtl/core/alsmp_pkg.sv
// ----------------------------------------------------------------------------
// Asymmetric Laplace sampler package
// Shared constants and types for the sampler core and its log2 pipeline.
// ----------------------------------------------------------------------------
package alsmp_pkg;

    localparam int UNIFORM_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF    = 16;

    localparam int LOG_IN_W  = 64;
    localparam int LOG_FRAC  = 30;
    localparam int LOG_P_W   = 6;
    localparam int LOG_OUT_W = LOG_P_W + LOG_FRAC;
    localparam int LOG_LAT   = LOG_FRAC + 1;

    localparam int RATIO_W = 48;
    localparam int SCALE_W = 32;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [31:0] LN2_Q32 = 32'hB17217F8;

    localparam logic [CFG_IDX_W-1:0] REG_LOCATION    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_SCALE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_SCALE = 2'd2;

    typedef struct packed {
        logic valid;
        logic left;
        logic zero;
        logic last;
    } side_t;

endpackage

// File: rtl/core/alsmp_log2_pipe.sv
// ----------------------------------------------------------------------------
// Pipelined log2
// Leading-one normalization followed by one square-and-compare stage per
// fractional bit; the result is the integer part and 30 fractional bits.
// ----------------------------------------------------------------------------
module alsmp_log2_pipe
(
    input  logic                            clk,
    input  logic                            en,
    input  logic [alsmp_pkg::LOG_IN_W-1:0]  value,
    output logic [alsmp_pkg::LOG_OUT_W-1:0] result
);

    localparam int NF = alsmp_pkg::LOG_FRAC;
    localparam int PW = alsmp_pkg::LOG_P_W;
    localparam int IW = alsmp_pkg::LOG_IN_W;

    logic [PW-1:0] p_reg    [0:NF];
    logic [31:0]   m_reg    [0:NF];
    logic [NF-1:0] frac_reg [0:NF];

    logic [PW-1:0] p_next;
    logic [IW-1:0] shifted;

    always_comb
    begin
        p_next = '0;
        for (int i = 0; i < IW; i++)
        begin
            if (value[i])
            begin
                p_next = PW'(i);
            end
        end
        shifted = value << (PW'(IW - 1) - p_next);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg[0]    <= p_next;
            m_reg[0]    <= shifted[IW-1:IW-32];
            frac_reg[0] <= '0;
        end
    end

    for (genvar k = 1; k <= NF; k++)
    begin : g_step
        logic [63:0] sq;
        logic [32:0] s;

        assign sq = 64'(m_reg[k-1]) * 64'(m_reg[k-1]);
        assign s  = sq[63:31];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                p_reg[k]    <= p_reg[k-1];
                m_reg[k]    <= s[32] ? s[32:1] : s[31:0];
                frac_reg[k] <= {frac_reg[k-1][NF-2:0], s[32]};
            end
        end
    end

    assign result = {p_reg[NF], frac_reg[NF]};

endmodule

// File: rtl/core/asymmetric_laplace_sampler_top.sv
// ----------------------------------------------------------------------------
// Asymmetric Laplace sampler
// Turns uniform draws into asymmetric Laplace variates by inverse transform.
//
// The input channel (in_valid/in_ready) takes one uniform code and a batch
// marker per request; the output channel (out_valid/out_ready) returns one
// saturated Q24.16 variate and the copied marker per request, in order.
// One request is taken per cycle while in_ready is high. A request reaches
// out_valid through an input register, the two 31-stage log2 pipelines and
// the six stages of multiply, add and saturate behind them.
// All stages advance together; while the receiver holds out_ready low with
// a result waiting, the whole pipeline holds and in_ready is low.
// The write port updates location and scales; after each write to one of
// them a shared restoring divider derives the split threshold and both
// ratios in three passes, each preceded by a load state; throughout,
// in_ready is low.
// Reset clears the pipeline, loads location 0 and unit scales, and sets the
// derived values to one half and two, so requests are taken right away.
// ----------------------------------------------------------------------------
module asymmetric_laplace_sampler_top
#(
    parameter int UNIFORM_BITS = alsmp_pkg::UNIFORM_BITS_DEF,
    parameter int FRAC_BITS    = alsmp_pkg::FRAC_BITS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [UNIFORM_BITS-1:0]           uniform_code,
    input  logic                              final_draw,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [24+FRAC_BITS-1:0]    variate,
    output logic                              final_sample,
    input  logic                              wr_en,
    input  logic [alsmp_pkg::CFG_IDX_W-1:0]   wr_index,
    input  logic [alsmp_pkg::CFG_W-1:0]       wr_data
);

    localparam int VAR_BITS = 24 + FRAC_BITS;
    localparam int W_W      = UNIFORM_BITS + 1;
    localparam int RW       = alsmp_pkg::RATIO_W;
    localparam int LAT      = alsmp_pkg::LOG_LAT;
    localparam int LOW      = alsmp_pkg::LOG_OUT_W;
    localparam int IX_L     = LAT + 1;
    localparam int IX_PE    = LAT + 2;
    localparam int IX_E     = LAT + 3;
    localparam int IX_PD    = LAT + 4;
    localparam int IX_D     = LAT + 5;
    localparam int NS       = LAT + 6;
    localparam int DIV_W    = (UNIFORM_BITS + 33 > 65) ? UNIFORM_BITS + 33 : 65;
    localparam int CNT_W    = $clog2(DIV_W + 1);
    localparam int SW       = (VAR_BITS + 1 > 42) ? VAR_BITS + 1 : 42;
    localparam int LW       = LOW + 2;

    localparam logic [LW-1:0] L_OFF = LW'(32 + UNIFORM_BITS) << alsmp_pkg::LOG_FRAC;

    typedef enum logic [1:0] {ST_IDLE, ST_LOAD, ST_DIV} dstate_t;
    typedef enum logic [1:0] {JOB_THR, JOB_LR, JOB_RR} job_t;

    // Configuration and derived values.
    logic [31:0]             location_reg;
    logic [31:0]             left_scale_reg;
    logic [31:0]             right_scale_reg;
    logic [UNIFORM_BITS-1:0] thr_reg;
    logic [RW-1:0]           lr_reg;
    logic [RW-1:0]           rr_reg;

    dstate_t          dstate_reg;
    job_t             job_reg;
    logic [DIV_W-1:0] dd_reg;
    logic [DIV_W-1:0] dq_reg;
    logic [33:0]      dr_reg;
    logic [32:0]      ds_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic [31:0] al_eff;
    logic [31:0] ar_eff;
    logic [32:0] a_sum;
    logic        busy;
    logic        cfg_hit;

    assign al_eff  = (left_scale_reg == '0) ? 32'd1 : left_scale_reg;
    assign ar_eff  = (right_scale_reg == '0) ? 32'd1 : right_scale_reg;
    assign a_sum   = 33'(al_eff) + 33'(ar_eff);
    assign busy    = (dstate_reg != ST_IDLE);
    assign cfg_hit = wr_en && (wr_index == alsmp_pkg::REG_LOCATION
                               || wr_index == alsmp_pkg::REG_LEFT_SCALE
                               || wr_index == alsmp_pkg::REG_RIGHT_SCALE);

    logic [33:0]      rs;
    logic             ge;
    logic [33:0]      r_new;
    logic [DIV_W-1:0] q_new;
    logic [DIV_W:0]   q_ceil;
    logic             last_step;

    assign rs        = {dr_reg[32:0], dd_reg[DIV_W-1]};
    assign ge        = (rs >= {1'b0, ds_reg});
    assign r_new     = ge ? rs - {1'b0, ds_reg} : rs;
    assign q_new     = {dq_reg[DIV_W-2:0], ge};
    assign q_ceil    = {1'b0, q_new} + (DIV_W+1)'(r_new != '0);
    assign last_step = (cnt_reg == CNT_W'(DIV_W - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            location_reg    <= '0;
            left_scale_reg  <= 32'h0001_0000;
            right_scale_reg <= 32'h0001_0000;
            thr_reg         <= {1'b1, {(UNIFORM_BITS-1){1'b0}}};
            lr_reg          <= RW'(64'h2_0000_0000);
            rr_reg          <= RW'(64'h2_0000_0000);
            dstate_reg      <= ST_IDLE;
            job_reg         <= JOB_THR;
            dd_reg          <= '0;
            dq_reg          <= '0;
            dr_reg          <= '0;
            ds_reg          <= '0;
            cnt_reg         <= '0;
        end
        else if (cfg_hit)
        begin
            job_reg    <= JOB_THR;
            dstate_reg <= ST_LOAD;
            unique case (wr_index)
                alsmp_pkg::REG_LOCATION:
                begin
                    location_reg <= wr_data;
                end
                alsmp_pkg::REG_LEFT_SCALE:
                begin
                    left_scale_reg <= wr_data;
                end
                default:
                begin
                    right_scale_reg <= wr_data;
                end
            endcase
        end
        else
        begin
            unique case (dstate_reg)
                ST_LOAD:
                begin
                    dq_reg  <= '0;
                    dr_reg  <= '0;
                    cnt_reg <= '0;
                    unique case (job_reg)
                        JOB_THR:
                        begin
                            dd_reg <= DIV_W'(al_eff) << UNIFORM_BITS;
                            ds_reg <= a_sum;
                        end
                        JOB_LR:
                        begin
                            dd_reg <= DIV_W'(a_sum) << 32;
                            ds_reg <= 33'(al_eff);
                        end
                        default:
                        begin
                            dd_reg <= DIV_W'(a_sum) << 32;
                            ds_reg <= 33'(ar_eff);
                        end
                    endcase
                    dstate_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    dd_reg  <= dd_reg << 1;
                    dq_reg  <= q_new;
                    dr_reg  <= r_new;
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (last_step)
                    begin
                        unique case (job_reg)
                            JOB_THR:
                            begin
                                thr_reg <= (|q_ceil[DIV_W:UNIFORM_BITS]) ? '1
                                         : q_ceil[UNIFORM_BITS-1:0];
                                job_reg    <= JOB_LR;
                                dstate_reg <= ST_LOAD;
                            end
                            JOB_LR:
                            begin
                                lr_reg     <= (|q_new[DIV_W-1:RW]) ? '1 : q_new[RW-1:0];
                                job_reg    <= JOB_RR;
                                dstate_reg <= ST_LOAD;
                            end
                            default:
                            begin
                                rr_reg     <= (|q_new[DIV_W-1:RW]) ? '1 : q_new[RW-1:0];
                                dstate_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Sample pipeline.
    logic en;
    logic out_valid_reg;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en && !busy;

    logic              left_in;
    logic [W_W-1:0]    w_in;
    alsmp_pkg::side_t  side_in;

    assign left_in = (uniform_code < thr_reg);
    assign w_in    = left_in ? {1'b0, uniform_code}
                   : ({1'b1, {UNIFORM_BITS{1'b0}}} - {1'b0, uniform_code});

    always_comb
    begin
        side_in.valid = in_valid && in_ready;
        side_in.left  = left_in;
        side_in.zero  = (w_in == '0);
        side_in.last  = final_draw;
    end

    alsmp_pkg::side_t side_reg [0:NS-1];
    logic [W_W-1:0]   w_s1_reg;
    logic [RW-1:0]    ratio_s1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NS; i++)
            begin
                side_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            side_reg[0] <= side_in;
            for (int i = 1; i < NS; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w_s1_reg     <= w_in;
            ratio_s1_reg <= left_in ? lr_reg : rr_reg;
        end
    end

    logic [LOW-1:0] lg_w;
    logic [LOW-1:0] lg_r;

    alsmp_log2_pipe u_log_w
    (
        .clk    (clk),
        .en     (en),
        .value  (alsmp_pkg::LOG_IN_W'(w_s1_reg)),
        .result (lg_w)
    );

    alsmp_log2_pipe u_log_r
    (
        .clk    (clk),
        .en     (en),
        .value  (alsmp_pkg::LOG_IN_W'(ratio_s1_reg)),
        .result (lg_r)
    );

    logic [LW-1:0] l_sum;
    logic [36:0]   e1_reg;
    logic [52:0]   pe_hi_reg;
    logic [47:0]   pe_lo_reg;
    logic [53:0]   e_sum;
    logic [36:0]   e_reg;
    logic [31:0]   scale_sel;
    logic [52:0]   pd_hi_reg;
    logic [47:0]   pd_lo_reg;
    logic [53:0]   d_sum;
    logic [39:0]   d_reg;

    assign l_sum     = LW'(lg_r) + LW'(lg_w) - L_OFF;
    assign e_sum     = 54'(pe_hi_reg) + 54'(pe_lo_reg[47:16]);
    assign scale_sel = side_reg[IX_E].left ? al_eff : ar_eff;
    assign d_sum     = 54'(pd_hi_reg) + 54'(pd_lo_reg[47:16]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // A positive logarithm is clamped to zero.
            e1_reg    <= l_sum[LW-1] ? 37'(-l_sum) : '0;
            pe_hi_reg <= 53'(e1_reg[36:16]) * 53'(alsmp_pkg::LN2_Q32);
            pe_lo_reg <= 48'(e1_reg[15:0]) * 48'(alsmp_pkg::LN2_Q32);
            e_reg     <= e_sum[52:16];
            pd_hi_reg <= 53'(scale_sel) * 53'(e_reg[36:16]);
            pd_lo_reg <= 48'(scale_sel) * 48'(e_reg[15:0]);
            d_reg     <= d_sum[53:14];
        end
    end

    logic signed [SW-1:0] m_ext;
    logic signed [SW-1:0] d_ext;
    logic signed [SW-1:0] v_sum;
    logic signed [SW-1:0] v_max;
    logic signed [SW-1:0] v_min;
    logic [VAR_BITS-1:0]  v_sat;

    assign m_ext = SW'($signed(location_reg));
    assign d_ext = $signed(SW'(d_reg));
    assign v_sum = side_reg[IX_D].left ? m_ext - d_ext : m_ext + d_ext;
    assign v_max = $signed({{(SW-VAR_BITS+1){1'b0}}, {(VAR_BITS-1){1'b1}}});
    assign v_min = $signed({{(SW-VAR_BITS+1){1'b1}}, {(VAR_BITS-1){1'b0}}});

    always_comb
    begin
        if (side_reg[IX_D].zero || v_sum < v_min)
        begin
            v_sat = v_min[VAR_BITS-1:0];
        end
        else if (v_sum > v_max)
        begin
            v_sat = v_max[VAR_BITS-1:0];
        end
        else
        begin
            v_sat = v_sum[VAR_BITS-1:0];
        end
    end

    logic [VAR_BITS-1:0] variate_reg;
    logic                final_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= side_reg[IX_D].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            variate_reg <= v_sat;
            final_reg   <= side_reg[IX_D].last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign variate      = $signed(variate_reg);
    assign final_sample = final_reg;

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Asymmetric Laplace sampler testbench
// Feeds uniform draws through the request channel under several location and
// scale settings, predicts each variate in fixed point and checks the results
// in order, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int  CLK_HALF    = 6;
    localparam int  CYCLE_LIMIT = 400000;
    localparam int  RAND_ITEMS  = 1950;
    localparam int  NUM_PHASES  = 9;
    localparam longint VAR_MAX  = (64'sd1 <<< 39) - 1;
    localparam longint VAR_MIN  = -VAR_MAX - 1;
    localparam logic [alsmp_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [31:0] code;
        logic        last;
    } draw_t;

    typedef struct packed {
        logic [39:0] value;
        logic        last;
    } sample_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [31:0]       uniform_code;
    logic              final_draw;
    logic              out_valid;
    logic              out_ready;
    logic signed [39:0] variate;
    logic              final_sample;
    logic              wr_en;
    logic [alsmp_pkg::CFG_IDX_W-1:0] wr_index;
    logic [alsmp_pkg::CFG_W-1:0]     wr_data;

    draw_t   pending_draws[$];
    sample_t expected_samples[$];

    logic [31:0] cur_location;
    logic [31:0] cur_left;
    logic [31:0] cur_right;
    logic [31:0] split_thr;
    logic [47:0] left_ratio;
    logic [47:0] right_ratio;

    int  send_idle_pct;
    int  recv_idle_pct;
    int  errors;
    int  checked;
    int  left_hits;
    int  right_hits;
    int  cycles;

    asymmetric_laplace_sampler_top DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .uniform_code (uniform_code),
        .final_draw   (final_draw),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .variate      (variate),
        .final_sample (final_sample),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data)
    );

    initial clk = 1'b0;
    always #CLK_HALF clk = ~clk;

    function automatic logic [63:0] nonzero_scale(logic [31:0] s);
        return (s == 0) ? 64'd1 : {32'd0, s};
    endfunction

    function automatic logic [47:0] scale_ratio(logic [63:0] total, logic [63:0] s);
        logic [63:0] ip;
        logic [63:0] rem;
        ip  = total / s;
        rem = total % s;
        if (ip >= 64'h10000)
            return 48'hFFFF_FFFF_FFFF;
        return {ip[15:0], 32'd0} | 48'((rem << 32) / s);
    endfunction

    function automatic void derive_split();
        logic [63:0] al;
        logic [63:0] ar;
        logic [63:0] total;
        logic [63:0] r;
        logic [63:0] q;
        int i;
        al    = nonzero_scale(cur_left);
        ar    = nonzero_scale(cur_right);
        total = al + ar;
        r     = al;
        q     = 0;
        for (i = 0; i < 32; i++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= total)
            begin
                r = r - total;
                q[0] = 1'b1;
            end
        end
        if (r != 0)
            q = q + 1;
        if (q > 64'hFFFF_FFFF)
            q = 64'hFFFF_FFFF;
        split_thr   = q[31:0];
        left_ratio  = scale_ratio(total, al);
        right_ratio = scale_ratio(total, ar);
    endfunction

    function automatic logic [35:0] log2_q30(logic [63:0] v);
        int p;
        int i;
        logic [63:0] mant;
        logic [29:0] frac;
        p = 63;
        while (p > 0 && !v[p])
            p--;
        if (p > 31)
            mant = v >> (p - 31);
        else
            mant = v << (31 - p);
        frac = 0;
        for (i = 29; i >= 0; i--)
        begin
            mant = (mant * mant) >> 31;
            if (mant[63:32] != 0)
            begin
                mant = mant >> 1;
                frac[i] = 1'b1;
            end
        end
        return {p[5:0], frac};
    endfunction

    function automatic logic [39:0] laplace_variate(logic [31:0] code);
        logic        on_left;
        logic [63:0] w;
        logic [63:0] ratio;
        logic [63:0] scale;
        logic [63:0] e1;
        logic [63:0] e;
        logic [63:0] d;
        longint      m;
        longint      l;
        longint      v;
        on_left = code < split_thr;
        w       = on_left ? {32'd0, code} : (64'h1_0000_0000 - code);
        ratio   = on_left ? {16'd0, left_ratio} : {16'd0, right_ratio};
        scale   = nonzero_scale(on_left ? cur_left : cur_right);
        m       = longint'(signed'(cur_location));
        if (w == 0)
            v = VAR_MIN;
        else
        begin
            l = longint'(log2_q30(ratio)) + longint'(log2_q30(w)) - (64'sd64 <<< 30);
            if (l > 0)
                l = 0;
            e1 = 64'(-l);
            e  = ((e1 >> 16) * alsmp_pkg::LN2_Q32
                  + (((e1 & 64'hFFFF) * alsmp_pkg::LN2_Q32) >> 16)) >> 16;
            d  = (scale * (e >> 16) + ((scale * (e & 64'hFFFF)) >> 16)) >> 14;
            v  = on_left ? m - longint'(d) : m + longint'(d);
            if (v > VAR_MAX)
                v = VAR_MAX;
            if (v < VAR_MIN)
                v = VAR_MIN;
        end
        return v[39:0];
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
        errors++;
    endtask

    // Request side: one item per handshake, prediction taken at acceptance.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid     <= 1'b0;
            uniform_code <= '0;
            final_draw   <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_samples.push_back({laplace_variate(uniform_code), final_draw});
                if (uniform_code < split_thr)
                    left_hits++;
                else
                    right_hits++;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_draws.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    draw_t nxt;
                    nxt = pending_draws.pop_front();
                    in_valid     <= 1'b1;
                    uniform_code <= nxt.code;
                    final_draw   <= nxt.last;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_samples.size() == 0)
                    report_mismatch("unexpected sample", {24'd0, variate}, 64'd0);
                else
                begin
                    sample_t want;
                    want = expected_samples.pop_front();
                    if (variate !== want.value)
                        report_mismatch("variate", {24'd0, variate}, {24'd0, want.value});
                    if (final_sample !== want.last)
                        report_mismatch("final_sample", 64'(final_sample), 64'(want.last));
                    checked++;
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_draws.size() != 0 || in_valid || expected_samples.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [alsmp_pkg::CFG_IDX_W-1:0] idx, logic [31:0] value);
        @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= value;
        @(posedge clk);
        wr_en    <= 1'b0;
        case (idx)
            alsmp_pkg::REG_LOCATION:    cur_location = value;
            alsmp_pkg::REG_LEFT_SCALE:  cur_left     = value;
            alsmp_pkg::REG_RIGHT_SCALE: cur_right    = value;
            default:                    ;
        endcase
        if (idx == alsmp_pkg::REG_LOCATION || idx == alsmp_pkg::REG_LEFT_SCALE
            || idx == alsmp_pkg::REG_RIGHT_SCALE)
            derive_split();
    endtask

    function automatic logic [31:0] random_code();
        logic [31:0] c;
        case ($urandom_range(4))
            0:       c = $urandom;
            1:       c = $urandom >> $urandom_range(31);
            2:       c = ~($urandom >> $urandom_range(31));
            3:       c = 32'(split_thr + $urandom_range(8) - 4);
            default: c = $urandom;
        endcase
        return (c == 0) ? 32'd1 : c;
    endfunction

    task automatic queue_random(int count);
        int i;
        for (i = 0; i < count; i++)
            pending_draws.push_back({random_code(), 1'($urandom_range(1))});
    endtask

    initial
    begin
        logic [31:0] loc_set[NUM_PHASES];
        logic [31:0] left_set[NUM_PHASES];
        logic [31:0] right_set[NUM_PHASES];
        int ph;
        int per_phase;
        rst_n = 1'b0;
        wr_en = 1'b0;
        wr_index = '0;
        wr_data = '0;
        errors = 0;
        checked = 0;
        left_hits = 0;
        right_hits = 0;
        cycles = 0;
        send_idle_pct = 19;
        recv_idle_pct = 80;
        cur_location = 32'd0;
        cur_left = 32'd65536;
        cur_right = 32'd65536;
        derive_split();

        loc_set   = '{32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0003_0000, 32'd0,
                      32'hFFFF_0000, $urandom, 32'h0001_8000, $urandom};
        left_set  = '{32'h0001_0000, 32'd1, 32'hFFFF_FFFF, 32'd0, 32'h0000_4000,
                      32'h0020_0000, $urandom, 32'h0001_0000, $urandom_range(1, 32'h80000)};
        right_set = '{32'h0001_0000, 32'hFFFF_FFFF, 32'd1, 32'h0002_0000, 32'd0,
                      32'h0000_8000, $urandom, 32'h0003_0000, $urandom_range(1, 32'h80000)};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        pending_draws.push_back({32'd0, 1'b0});
        pending_draws.push_back({32'd1, 1'b1});
        pending_draws.push_back({32'd2, 1'b0});
        pending_draws.push_back({32'hFFFF_FFFF, 1'b1});
        pending_draws.push_back({32'hFFFF_FFFE, 1'b0});
        pending_draws.push_back({32'h8000_0000, 1'b0});
        pending_draws.push_back({32'h7FFF_FFFF, 1'b1});
        pending_draws.push_back({32'h5555_5555, 1'b0});
        pending_draws.push_back({32'hAAAA_AAAA, 1'b1});
        pending_draws.push_back({32'h0001_0000, 1'b0});
        wait_drained();

        write_reg(REG_UNUSED, 32'hDEAD_BEEF);
        per_phase = RAND_ITEMS / NUM_PHASES;
        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            if (ph == 3)
            begin
                send_idle_pct = 80;
                recv_idle_pct = 19;
            end
            else if (ph == 6)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            wait_drained();
            write_reg(alsmp_pkg::REG_LOCATION, loc_set[ph]);
            write_reg(alsmp_pkg::REG_LEFT_SCALE, left_set[ph]);
            write_reg(alsmp_pkg::REG_RIGHT_SCALE, right_set[ph]);
            pending_draws.push_back({split_thr - 32'd1, 1'b0});
            pending_draws.push_back({split_thr, 1'b1});
            pending_draws.push_back({split_thr + 32'd1, 1'b0});
            queue_random(per_phase / 2);
            wait_drained();
            queue_random(per_phase - per_phase / 2);
        end

        wait_drained();
        repeat (60) @(posedge clk);
        if (expected_samples.size() != 0)
            report_mismatch("missing samples", 64'(expected_samples.size()), 64'd0);
        $display("Checked %0d samples over %0d register settings (%0d left, %0d right).",
                 checked, NUM_PHASES + 1, left_hits, right_hits);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
